// ----- rtl/core/dht_pkg.sv -----
// Package for the double hash table engine: status and command codes,
// default sizes, shared request type. No dependencies.
`default_nettype none
package dht_pkg;
    localparam int DEF_SLOTS      = 1024;
    localparam int DEF_VALUE_BITS = 32;

    localparam logic [1:0] CMD_FIND   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_BAD    = 2'd3;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_USED      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_BAD       = 3'd6;

    localparam logic [9:0] SIZE_RESET = 10'd1021;

    // request handed from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] hash_value;
        logic [31:0] key;
        logic [63:0] value;
        logic [9:0]  slot_index;
    } dht_req_t;
endpackage
`default_nettype wire

// ----- rtl/core/dht_front.sv -----
// Front part: accepts requests, forces zero hash to one, queues them in a
// two-entry FIFO for the back part. Depends on dht_pkg.
`default_nettype none
module dht_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire [1:0]         cmd,
    input  wire [31:0]        hash_value,
    input  wire [31:0]        key,
    input  wire [31:0]        value,
    input  wire [9:0]         slot_index,
    output logic              q_valid,
    input  wire               q_take,
    output dht_pkg::dht_req_t q_req
);
    import dht_pkg::*;

    dht_req_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    dht_req_t   req_in;
    logic       push, pop;

    always_comb
    begin
        req_in.cmd        = cmd;
        req_in.hash_value = (hash_value == 32'd0) ? 32'd1 : hash_value;
        req_in.key        = key;
        req_in.value      = {32'd0, value};
        req_in.slot_index = slot_index;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_req    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/dht_back.sv -----
// Back part: modulo reductions, probe walk over the slot memories, insert,
// clearing pass, output register. Depends on dht_pkg.
`default_nettype none
module dht_back #(
    parameter int SLOTS      = dht_pkg::DEF_SLOTS,
    parameter int VALUE_BITS = dht_pkg::DEF_VALUE_BITS
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire [9:0]         table_size,
    input  wire               q_valid,
    output logic              q_take,
    input  dht_pkg::dht_req_t q_req,
    output logic              out_valid,
    input  wire               out_stall,
    output logic [2:0]        status,
    output logic [9:0]        slot,
    output logic [31:0]       found_key,
    output logic [31:0]       found_value,
    output logic              busy
);
    import dht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_WR    = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [31:0]         tag_mem [SLOTS];
    logic [31:0]         key_mem [SLOTS];
    logic [VALUE_BITS-1:0] val_mem [SLOTS];

    logic [3:0]  st_reg, st_next;
    dht_req_t    rq_reg;
    logic [AW-1:0] clr_reg;
    logic [10:0] size_reg, size2_reg;
    // restoring dividers: remainders of hash by size and size-2
    logic [10:0] r1_reg, r2_reg;
    logic [5:0]  bit_reg;
    logic [10:0] pos_reg, start_reg, step_reg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0] rd_tag, rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [10:0] count_reg;
    logic [2:0]  ost_reg;
    logic [9:0]  oslot_reg;
    logic [31:0] okey_reg, oval_reg;
    logic        ovld_reg;
    logic [10:0] size_use;
    logic [11:0] t1, t2;
    logic [10:0] next_pos;
    logic [31:0] vzx;
    logic [31:0] vins;
    logic        rq_short;
    logic        rd_hit;

    always_comb
    begin
        size_use = {1'b0, table_size};
        if (size_use < 11'd3)
        begin
            size_use = 11'd3;
        end
        if (size_use > 11'(SLOTS - 1))
        begin
            size_use = 11'(SLOTS - 1);
        end
    end

    assign t1 = {r1_reg, rq_reg.hash_value[bit_reg[4:0]]};
    assign t2 = {r2_reg, rq_reg.hash_value[bit_reg[4:0]]};
    assign next_pos = (pos_reg <= step_reg) ? size_reg + pos_reg - step_reg
                                            : pos_reg - step_reg;
    assign rd_addr = (st_reg == S_IDLE) ? AW'(q_req.slot_index) : AW'(pos_reg);
    assign rq_short = (rq_reg.cmd == CMD_READ) || (rq_reg.cmd == CMD_BAD);
    assign rd_hit   = (rd_tag == rq_reg.hash_value) && (rd_key == rq_reg.key);

    always_comb
    begin
        vzx = '0;
        vzx[VW-1:0] = rd_val[VW-1:0];
        vins = '0;
        vins[VW-1:0] = rq_reg.value[VW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_CLEAR)
        begin
            tag_mem[clr_reg] <= 32'd0;
        end
        else if (st_reg == S_WR)
        begin
            tag_mem[AW'(pos_reg)] <= rq_reg.hash_value;
            key_mem[AW'(pos_reg)] <= rq_reg.key;
            val_mem[AW'(pos_reg)] <= rq_reg.value[VALUE_BITS-1:0];
        end
        if (rd_en)
        begin
            rd_tag <= tag_mem[rd_addr];
            rd_key <= key_mem[rd_addr];
            rd_val <= val_mem[rd_addr];
        end
    end

    assign rd_en  = (st_reg == S_RD) || (st_reg == S_IDLE);
    assign q_take = (st_reg == S_IDLE) && q_valid && !ovld_reg;
    assign busy   = (st_reg != S_IDLE) || ovld_reg || q_valid;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_CLEAR: if (clr_reg == AW'(SLOTS - 1)) st_next = S_IDLE;
            S_IDLE:
            begin
                if (q_take)
                begin
                    st_next = (q_req.cmd == CMD_READ || q_req.cmd == CMD_BAD) ? S_WAIT
                                                                             : S_MOD;
                end
            end
            S_MOD:   if (bit_reg == 6'd0) st_next = S_RD;
            S_RD:    st_next = S_WAIT;
            S_WAIT:  st_next = rq_short ? S_IDLE : S_CHK;
            S_CHK:
            begin
                if (rd_tag == 32'd0)
                begin
                    st_next = (rq_reg.cmd == CMD_INSERT) ? S_WR : S_IDLE;
                end
                else if (rd_hit || next_pos == start_reg)
                begin
                    st_next = S_IDLE;
                end
                else
                begin
                    st_next = S_RD;
                end
            end
            S_WR:    st_next = S_OUT;
            S_OUT:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            rq_reg    <= q_req;
            size_reg  <= size_use;
            size2_reg <= size_use - 11'd2;
            r1_reg    <= '0;
            r2_reg    <= '0;
        end
        else if (st_reg == S_MOD)
        begin
            r1_reg <= (t1 >= {1'b0, size_reg})  ? 11'(t1 - {1'b0, size_reg})  : t1[10:0];
            r2_reg <= (t2 >= {1'b0, size2_reg}) ? 11'(t2 - {1'b0, size2_reg}) : t2[10:0];
            if (bit_reg == 6'd0)
            begin
                pos_reg   <= ((t1 >= {1'b0, size_reg}) ? 11'(t1 - {1'b0, size_reg})
                                                        : t1[10:0]) + 11'd1;
                start_reg <= ((t1 >= {1'b0, size_reg}) ? 11'(t1 - {1'b0, size_reg})
                                                        : t1[10:0]) + 11'd1;
                step_reg  <= ((t2 >= {1'b0, size2_reg}) ? 11'(t2 - {1'b0, size2_reg})
                                                         : t2[10:0]) + 11'd1;
            end
        end
        else if (st_reg == S_CHK && rd_tag != 32'd0 && !rd_hit)
        begin
            pos_reg <= next_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLEAR;
            clr_reg   <= '0;
            bit_reg   <= 6'd31;
            count_reg <= '0;
            ovld_reg  <= 1'b0;
            ost_reg   <= ST_BAD;
            oslot_reg <= '0;
            okey_reg  <= '0;
            oval_reg  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (ovld_reg && !out_stall)
            begin
                ovld_reg <= 1'b0;
            end
            case (st_reg)
                S_CLEAR: clr_reg <= clr_reg + AW'(1);
                S_IDLE:  bit_reg <= 6'd31;
                S_MOD:   bit_reg <= bit_reg - 6'd1;
                S_WAIT:
                begin
                    if (rq_reg.cmd == CMD_BAD)
                    begin
                        ovld_reg <= 1'b1;
                        ost_reg <= ST_BAD; oslot_reg <= '0;
                        okey_reg <= '0; oval_reg <= '0;
                    end
                    else if (rq_reg.cmd == CMD_READ)
                    begin
                        ovld_reg <= 1'b1;
                        oslot_reg <= rq_reg.slot_index;
                        if ({1'b0, rq_reg.slot_index} > size_use)
                        begin
                            ost_reg <= ST_BAD; okey_reg <= '0; oval_reg <= '0;
                        end
                        else if (rd_tag != 32'd0)
                        begin
                            ost_reg <= ST_USED; okey_reg <= rd_key; oval_reg <= vzx;
                        end
                        else
                        begin
                            ost_reg <= ST_EMPTY; okey_reg <= '0; oval_reg <= '0;
                        end
                    end
                end
                S_CHK:
                begin
                    if (rd_tag == 32'd0)
                    begin
                        if (rq_reg.cmd != CMD_INSERT)
                        begin
                            ovld_reg <= 1'b1;
                            ost_reg <= ST_NOT_FOUND; oslot_reg <= '0;
                            okey_reg <= '0; oval_reg <= '0;
                        end
                    end
                    else if (rd_hit)
                    begin
                        ovld_reg <= 1'b1;
                        ost_reg <= ST_FOUND; oslot_reg <= pos_reg[9:0];
                        okey_reg <= rd_key; oval_reg <= vzx;
                    end
                    else if (next_pos == start_reg)
                    begin
                        ovld_reg <= 1'b1;
                        ost_reg <= (rq_reg.cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                        oslot_reg <= '0; okey_reg <= '0; oval_reg <= '0;
                    end
                end
                S_WR:
                begin
                    if (count_reg != 11'h7FF)
                    begin
                        count_reg <= count_reg + 11'd1;
                    end
                end
                S_OUT:
                begin
                    ovld_reg <= 1'b1;
                    ost_reg <= ST_INSERTED; oslot_reg <= pos_reg[9:0];
                    okey_reg <= rq_reg.key;
                    oval_reg <= vins;
                end
                default: ;
            endcase
        end
    end

    assign out_valid   = ovld_reg;
    assign status      = ost_reg;
    assign slot        = oslot_reg;
    assign found_key   = okey_reg;
    assign found_value = oval_reg;
endmodule
`default_nettype wire

// ----- rtl/core/double_hash_table_engine.sv -----
// Double hash table engine, top level. Instantiates dht_front and dht_back
// and holds the table_size register. Depends on dht_pkg.
//
// Usage: requests enter on in_valid/in_stall with cmd, hash_value, key,
// value, slot_index; one result leaves per request on out_valid/out_stall
// with status, slot, found_key, found_value, in request order.
// table_size is written on cfg_valid/cfg_ready; cfg_ready is low while any
// request is queued, in the back end or waiting at the output.
// Flow: a read-slot or bad command is taken from the queue with its slot read
// issued, then its result is registered; find and insert take the queue
// hand-off, then the two bit-serial remainders, which run side by side, then
// per probe a memory read, register and compare, then on insert a write.
// The back end holds one request at a time; the next is taken in the cycle
// after the result is accepted. A two-entry request queue keeps
// accepting while the back end works.
// After reset a clearing pass over every slot zeroes the tag memory; no
// request is taken from the queue until it ends. When the receiver stalls,
// the result holds and the back end waits; the queue then fills and
// in_stall rises.
`default_nettype none
module double_hash_table_engine #(
    parameter int SLOTS      = dht_pkg::DEF_SLOTS,
    parameter int VALUE_BITS = dht_pkg::DEF_VALUE_BITS
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire [1:0]  cmd,
    input  wire [31:0] hash_value,
    input  wire [31:0] key,
    input  wire [31:0] value,
    input  wire [9:0]  slot_index,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [2:0] status,
    output logic [9:0] slot,
    output logic [31:0] found_key,
    output logic [31:0] found_value,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [9:0]  cfg_data
);
    import dht_pkg::*;

    logic [9:0] size_reg;
    logic       q_valid, q_take, busy;
    dht_req_t   q_req;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    dht_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .hash_value(hash_value), .key(key), .value(value),
        .slot_index(slot_index), .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
    );

    dht_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .table_size(size_reg), .q_valid(q_valid),
        .q_take(q_take), .q_req(q_req), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .slot(slot),
        .found_key(found_key), .found_value(found_value), .busy(busy)
    );
endmodule
`default_nettype wire

// ----- rtl/core/dht_checker.sv -----
// Port-level checker for the double hash table engine, bound to the top.
// Depends on dht_pkg.
`default_nettype none
module dht_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_stall,
    input wire [2:0]  status,
    input wire [9:0]  slot,
    input wire [31:0] found_key,
    input wire [31:0] found_value
);
    import dht_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot))
        else $error("result changed under stall");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 3'd7)
        else $error("bad status");
    a_nf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND || status == ST_FULL) |->
        slot == 10'd0 && found_key == 32'd0 && found_value == 32'd0)
        else $error("miss result not zero");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> found_key == 32'd0 && found_value == 32'd0)
        else $error("empty slot data not zero");
endmodule

bind double_hash_table_engine dht_checker u_dht_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .slot(slot), .found_key(found_key), .found_value(found_value)
);
`default_nettype wire

// ----- tb/double_hash_table_engine_test.sv -----
// Self-checking testbench for double_hash_table_engine: directed table, then random
// requests over several table sizes, checked against an in-bench table model.
// Depends on dht_pkg and the engine RTL.
`timescale 1ns / 1ps
module double_hash_table_engine_test;
    import dht_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] hash_value;
        logic [31:0] key;
        logic [31:0] value;
        logic [9:0]  slot_index;
    } lookup_req_t;

    typedef struct {
        logic [2:0]  status;
        logic [9:0]  slot;
        logic [31:0] key;
        logic [31:0] value;
    } lookup_rsp_t;

    typedef struct {
        lookup_req_t req;
        bit          typed;
        lookup_rsp_t rsp;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [31:0] hash_value;
    logic [31:0] key;
    logic [31:0] value;
    logic [9:0]  slot_index;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [9:0]  cfg_data;

    // table model
    logic [31:0] tag_mem [1024];
    logic [31:0] key_mem [1024];
    logic [31:0] val_mem [1024];
    logic [9:0]  size_reg;
    int          inserted_count;

    lookup_rsp_t pending_rsp [$];
    int          error_count;
    int          idle_cycles;
    bit          no_gaps;

    double_hash_table_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .hash_value(hash_value), .key(key), .value(value),
        .slot_index(slot_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .slot(slot), .found_key(found_key), .found_value(found_value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic lookup_rsp_t mk_rsp(logic [2:0] st, logic [9:0] sl,
                                           logic [31:0] k, logic [31:0] v);
        lookup_rsp_t r;
        r.status = st;
        r.slot   = sl;
        r.key    = k;
        r.value  = v;
        return r;
    endfunction

    // walks the probe sequence and updates the table model
    function automatic lookup_rsp_t table_lookup(lookup_req_t rq);
        int unsigned sz;
        int unsigned hv;
        int unsigned pos;
        int unsigned start;
        int unsigned stride;
        bit          hit_empty;
        sz = size_reg < 3 ? 3 : size_reg;
        hit_empty = 1'b0;
        if (rq.cmd == CMD_READ)
        begin
            if (rq.slot_index > sz)
                return mk_rsp(ST_BAD, rq.slot_index, 0, 0);
            if (tag_mem[rq.slot_index] != 0)
                return mk_rsp(ST_USED, rq.slot_index, key_mem[rq.slot_index],
                              val_mem[rq.slot_index]);
            return mk_rsp(ST_EMPTY, rq.slot_index, 0, 0);
        end
        if (rq.cmd == CMD_BAD)
            return mk_rsp(ST_BAD, 0, 0, 0);
        hv = (rq.hash_value == 0) ? 1 : rq.hash_value;
        pos = hv % sz + 1;
        start = pos;
        stride = 1 + hv % (sz - 2);
        forever
        begin
            if (tag_mem[pos] == 0)
            begin
                hit_empty = 1'b1;
                break;
            end
            if (tag_mem[pos] == hv && key_mem[pos] == rq.key)
                return mk_rsp(ST_FOUND, 10'(pos), key_mem[pos], val_mem[pos]);
            pos = (pos <= stride) ? sz + pos - stride : pos - stride;
            if (pos == start)
                break;
        end
        if (rq.cmd == CMD_FIND)
            return mk_rsp(ST_NOT_FOUND, 0, 0, 0);
        if (!hit_empty)
            return mk_rsp(ST_FULL, 0, 0, 0);
        tag_mem[pos] = hv;
        key_mem[pos] = rq.key;
        val_mem[pos] = rq.value;
        if (inserted_count < 2047)
            inserted_count++;
        return mk_rsp(ST_INSERTED, 10'(pos), rq.key, rq.value);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        lookup_rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected result status", 32'(status), 32'd0);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (slot !== want.slot)
                    report_mismatch("slot", 32'(slot), 32'(want.slot));
                if (found_key !== want.key)
                    report_mismatch("found_key", found_key, want.key);
                if (found_value !== want.value)
                    report_mismatch("found_value", found_value, want.value);
            end
        end
    end

    always @(negedge clk)
        out_stall <= (!no_gaps && $urandom_range(99) < 20);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_request(lookup_req_t rq, bit typed, lookup_rsp_t typed_rsp);
        lookup_rsp_t predicted;
        while (!no_gaps && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= rq.cmd;
        hash_value <= rq.hash_value;
        key        <= rq.key;
        value      <= rq.value;
        slot_index <= rq.slot_index;
        do @(posedge clk); while (in_stall);
        predicted = table_lookup(rq);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_size(logic [9:0] sz);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= sz;
        do @(posedge clk); while (!cfg_ready);
        size_reg = sz;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic lookup_req_t random_request();
        lookup_req_t rq;
        int unsigned sz;
        int unsigned pool;
        int unsigned pick;
        sz = size_reg < 3 ? 3 : size_reg;
        pool = (2 * sz < 200) ? 2 * sz : 200;
        pick = $urandom_range(99);
        rq.key = $urandom_range(pool);
        rq.hash_value = rq.key * 32'h9E3779B1;
        if ($urandom_range(19) == 0)
            rq.hash_value = 0;
        rq.value = $urandom;
        rq.slot_index = 10'($urandom_range(sz + 2));
        if (pick < 45)
            rq.cmd = CMD_INSERT;
        else if (pick < 80)
            rq.cmd = CMD_FIND;
        else if (pick < 95)
            rq.cmd = CMD_READ;
        else
        begin
            rq.cmd = 2'($urandom_range(3));
            rq.hash_value = $urandom;
            rq.key = $urandom;
            rq.slot_index = 10'($urandom_range(1023));
        end
        return rq;
    endfunction

    dir_row_t dir_rows [$];
    int       phase_size  [11] = '{3, 0, 2, 7, 13, 9, 31, 1, 1023, 101, 1021};
    int       phase_count [11] = '{60, 40, 30, 120, 150, 120, 250, 30, 300, 300, 500};

    function automatic dir_row_t row(logic [1:0] c, logic [31:0] h, logic [31:0] k,
                                     logic [31:0] v, logic [9:0] i, bit t,
                                     logic [2:0] st, logic [9:0] sl,
                                     logic [31:0] fk, logic [31:0] fv);
        dir_row_t r;
        r.req.cmd = c;
        r.req.hash_value = h;
        r.req.key = k;
        r.req.value = v;
        r.req.slot_index = i;
        r.typed = t;
        r.rsp = mk_rsp(st, sl, fk, fv);
        return r;
    endfunction

    initial
    begin
        lookup_rsp_t none;
        none = mk_rsp(0, 0, 0, 0);
        error_count = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        inserted_count = 0;
        size_reg = SIZE_RESET;
        for (int i = 0; i < 1024; i++)
            tag_mem[i] = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_FIND;
        hash_value = 0;
        key = 0;
        value = 0;
        slot_index = 0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset size
        dir_rows.push_back(row(CMD_READ, 0, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(row(CMD_READ, 0, 0, 0, 1021, 1, ST_EMPTY, 1021, 0, 0));
        dir_rows.push_back(row(CMD_READ, 0, 0, 0, 1022, 1, ST_BAD, 1022, 0, 0));
        dir_rows.push_back(row(CMD_READ, '1, '1, '1, 1023, 1, ST_BAD, 1023, 0, 0));
        dir_rows.push_back(row(CMD_FIND, 0, 5, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0));
        dir_rows.push_back(row(CMD_BAD, '1, '1, '1, '1, 1, ST_BAD, 0, 0, 0));
        dir_rows.push_back(row(CMD_INSERT, 0, 5, 1, 0, 1, ST_INSERTED, 2, 5, 1));
        dir_rows.push_back(row(CMD_FIND, 1, 5, 0, 0, 1, ST_FOUND, 2, 5, 1));
        dir_rows.push_back(row(CMD_FIND, 0, 5, 0, 0, 1, ST_FOUND, 2, 5, 1));
        dir_rows.push_back(row(CMD_INSERT, 1, 5, 9, 0, 1, ST_FOUND, 2, 5, 1));
        dir_rows.push_back(row(CMD_INSERT, 1, 6, 7, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(CMD_INSERT, '1, '1, '1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(CMD_FIND, '1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(CMD_FIND, '1, '1, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(CMD_READ, 0, 0, 0, 2, 1, ST_USED, 2, 5, 1));
        dir_rows.push_back(row(CMD_READ, 0, 0, 0, 1021, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(CMD_INSERT, 1020, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(CMD_INSERT, 32'h8000_0000, 32'h5555_AAAA, 32'hAAAA_5555,
                               0, 0, 0, 0, 0, 0));
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

        // random part over a range of sizes; the phase at size 31 runs with no gaps
        foreach (phase_size[p])
        begin
            write_size(10'(phase_size[p]));
            no_gaps = (p == 6);
            for (int n = 0; n < phase_count[p]; n++)
            begin
                send_request(random_request(), 0, none);
                if (p == 9 && n == 150)
                    drain();
            end
            no_gaps = 1'b0;
        end

        drain();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/dht_pkg.sv
rtl/core/dht_front.sv
rtl/core/dht_back.sv
rtl/core/double_hash_table_engine.sv
rtl/core/dht_checker.sv
tb/double_hash_table_engine_test.sv
